FILE: design/wgm_pkg.sv
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types and constants of the wildcard glob matcher.
// ----------------------------------------------------------------------------
package wgm_pkg;

    localparam int unsigned SYM_W      = 8;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned LEN_W      = 5;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_SYMS   = 16;  // symbols held in configuration

    localparam logic [SYM_W-1:0] SYM_STAR = 8'd42;
    localparam logic [SYM_W-1:0] SYM_ANY  = 8'd63;

    typedef logic [SYM_W-1:0] t_sym;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYM_LOW  = 2'd0,
        CFG_SYM_HIGH = 2'd1,
        CFG_LENGTH   = 2'd2
    } t_cfg_index;

endpackage

FILE: design/wgm_cfg_regs.sv
// ----------------------------------------------------------------------------
// wgm_cfg_regs
// Pattern registers, symbol unpacking and saturated pattern length.
// ----------------------------------------------------------------------------
module wgm_cfg_regs
    import wgm_pkg::*;
#(
    parameter int unsigned PATTERN_SYMBOLS = 16,
    parameter int unsigned LW              = $clog2(PATTERN_SYMBOLS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_sym                  o_sym [PATTERN_SYMBOLS],
    output logic [LW-1:0]         o_len
);

    localparam int unsigned CW = (LW > LEN_W) ? LW : LEN_W;

    logic [CFG_DATA_W-1:0] r_sym_low;
    logic [CFG_DATA_W-1:0] r_sym_high;
    logic [LEN_W-1:0]      r_len;
    logic [CW-1:0]         len_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_low  <= '0;
            r_sym_high <= '0;
            r_len      <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_SYM_LOW:  r_sym_low  <= i_cfg_data;
                CFG_SYM_HIGH: r_sym_high <= i_cfg_data;
                CFG_LENGTH:   r_len      <= i_cfg_data[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    for (genvar k = 0; k < PATTERN_SYMBOLS; k++) begin : g_sym
        if (k < CFG_SYMS / 2) begin : g_low
            assign o_sym[k] = r_sym_low[SYM_W*k +: SYM_W];
        end else if (k < CFG_SYMS) begin : g_high
            assign o_sym[k] = r_sym_high[SYM_W*(k - CFG_SYMS/2) +: SYM_W];
        end else begin : g_zero
            assign o_sym[k] = '0;
        end
    end

    assign len_ext = CW'(r_len);
    assign o_len   = (len_ext > CW'(PATTERN_SYMBOLS)) ? LW'(PATTERN_SYMBOLS)
                                                      : LW'(len_ext);

endmodule

FILE: design/wgm_row_update.sv
// ----------------------------------------------------------------------------
// wgm_row_update
// One step of the match row: start-row rebuild and, when present, one text byte.
// ----------------------------------------------------------------------------
module wgm_row_update
    import wgm_pkg::*;
#(
    parameter int unsigned PATTERN_SYMBOLS = 16,
    parameter int unsigned LW              = $clog2(PATTERN_SYMBOLS + 1)
) (
    input  t_sym                       i_sym [PATTERN_SYMBOLS],
    input  logic [LW-1:0]              i_len,
    input  logic [PATTERN_SYMBOLS:0]   i_row,
    input  logic                       i_at_start,
    input  logic [SYM_W-1:0]           i_char,
    input  logic                       i_has_char,
    output logic [PATTERN_SYMBOLS:0]   o_row,
    output logic                       o_matched
);

    logic [PATTERN_SYMBOLS:0] start_row;
    logic [PATTERN_SYMBOLS:0] base_row;
    logic [PATTERN_SYMBOLS:0] step_row;

    always_comb begin
        start_row    = '0;
        start_row[0] = 1'b1;
        for (int j = 1; j <= PATTERN_SYMBOLS; j++) begin
            start_row[j] = (LW'(j) <= i_len) && (i_sym[j-1] == SYM_STAR)
                           && start_row[j-1];
        end
    end

    assign base_row = i_at_start ? start_row : i_row;

    always_comb begin
        step_row = '0;
        for (int j = 1; j <= PATTERN_SYMBOLS; j++) begin
            if (LW'(j) <= i_len) begin
                if (i_sym[j-1] == SYM_STAR) begin
                    step_row[j] = step_row[j-1] | base_row[j];
                end else begin
                    step_row[j] = base_row[j-1]
                                  && ((i_sym[j-1] == i_char) || (i_sym[j-1] == SYM_ANY));
                end
            end
        end
    end

    assign o_row     = i_has_char ? step_row : base_row;
    assign o_matched = o_row[i_len];

endmodule

FILE: design/wildcard_glob_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// Each accepted item is held in the input register, and its result then in the result register.
// Throughput: one text byte per cycle unless the result side stalls; the row update is combinational.
// Reset: synchronous, active low; pattern registers clear, row clears and the
// next item starts a new string.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher
    import wgm_pkg::*;
#(
    parameter int unsigned PATTERN_SYMBOLS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // text items
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // [7:0] text_char
    input  logic                  i_s_axis_tuser,   // [0] has_char
    input  logic                  i_s_axis_tlast,   // last_char
    // result items
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [7:0]            o_m_axis_tdata,   // [0] matched, [7:1] zero
    output logic                  o_m_axis_tlast    // end_of_text
);

    localparam int unsigned LW = $clog2(PATTERN_SYMBOLS + 1);

    t_sym                     sym [PATTERN_SYMBOLS];
    logic [LW-1:0]            len;

    logic                     r_in_valid;
    logic [SYM_W-1:0]         r_char;
    logic                     r_has;
    logic                     r_last;

    logic                     r_out_valid;
    logic                     r_matched;
    logic                     r_eot;

    logic [PATTERN_SYMBOLS:0] r_row;
    logic                     r_at_start;

    logic [PATTERN_SYMBOLS:0] n_row;
    logic                     n_matched;
    logic                     out_free;
    logic                     advance;
    logic                     in_take;

    wgm_cfg_regs #(
        .PATTERN_SYMBOLS (PATTERN_SYMBOLS),
        .LW              (LW)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_sym       (sym),
        .o_len       (len)
    );

    wgm_row_update #(
        .PATTERN_SYMBOLS (PATTERN_SYMBOLS),
        .LW              (LW)
    ) u_row (
        .i_sym      (sym),
        .i_len      (len),
        .i_row      (r_row),
        .i_at_start (r_at_start),
        .i_char     (r_char),
        .i_has_char (r_has),
        .o_row      (n_row),
        .o_matched  (n_matched)
    );

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_char <= i_s_axis_tdata;
            r_has  <= i_s_axis_tuser;
            r_last <= i_s_axis_tlast;
        end
    end

    // row state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_at_start  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_row       <= n_row;
                r_at_start  <= r_last;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_matched <= n_matched;
            r_eot     <= r_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_matched};
    assign o_m_axis_tlast  = r_eot;

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for wildcard_glob_matcher. A directed table covers empty
// text and pattern, saturated length, byte extremes and a pattern swap inside
// a string. Random phases follow, each with a new pattern (not every register
// is rewritten) and text mostly built to fit it. A local row model predicts the
// results not typed in the table; random bursts of idle cycles fall on both stream sides.
// ----------------------------------------------------------------------------
module tb;
    import wgm_pkg::*;

    localparam int ITEM_GOAL = 1350;

    typedef struct packed {
        logic matched;
        logic end_of_text;
    } answer_t;

    typedef enum bit {STEP_WRITE, STEP_TEXT} step_kind_e;

    typedef struct {
        step_kind_e  kind;
        t_cfg_index  reg_idx;
        logic [63:0] value;
        logic [7:0]  ch;
        bit          has;
        bit          last;
        bit          typed;   // want holds the answer
        bit          want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 29;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // empty pattern
        '{STEP_TEXT,  CFG_SYM_LOW,  64'd0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1},
        '{STEP_TEXT,  CFG_SYM_LOW,  64'd0, 8'h61, 1'b1, 1'b1, 1'b1, 1'b0},
        '{STEP_TEXT,  CFG_SYM_LOW,  64'd0, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0},
        '{STEP_TEXT,  CFG_SYM_LOW,  64'd0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0},
        // "a*?"
        '{STEP_WRITE, CFG_SYM_LOW,  64'h3F2A61, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_WRITE, CFG_LENGTH,   64'd3, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_TEXT,  CFG_SYM_LOW,  64'd0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0},
        '{STEP_TEXT,  CFG_SYM_LOW,  64'd0, 8'h61, 1'b1, 1'b0, 1'b0, 1'b0},
        '{STEP_TEXT,  CFG_SYM_LOW,  64'd0, 8'h78, 1'b1, 1'b0, 1'b0, 1'b0},
        '{STEP_TEXT,  CFG_SYM_LOW,  64'd0, 8'h79, 1'b1, 1'b1, 1'b0, 1'b0},
        '{STEP_TEXT,  CFG_SYM_LOW,  64'd0, 8'h61, 1'b1, 1'b0, 1'b0, 1'b0},
        '{STEP_TEXT,  CFG_SYM_LOW,  64'd0, 8'h62, 1'b1, 1'b1, 1'b0, 1'b0},
        // sixteen stars, length above range
        '{STEP_WRITE, CFG_SYM_LOW,  64'h2A2A2A2A2A2A2A2A, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_WRITE, CFG_SYM_HIGH, 64'h2A2A2A2A2A2A2A2A, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_WRITE, CFG_LENGTH,   64'd31, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_TEXT,  CFG_SYM_LOW,  64'd0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1},
        '{STEP_TEXT,  CFG_SYM_LOW,  64'd0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1},
        '{STEP_TEXT,  CFG_SYM_LOW,  64'd0, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b1},
        '{STEP_TEXT,  CFG_SYM_LOW,  64'd0, 8'h2A, 1'b1, 1'b1, 1'b1, 1'b1},
        // literal byte extremes
        '{STEP_WRITE, CFG_SYM_LOW,  64'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_WRITE, CFG_LENGTH,   64'd1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_TEXT,  CFG_SYM_LOW,  64'd0, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0},
        '{STEP_TEXT,  CFG_SYM_LOW,  64'd0, 8'hFE, 1'b1, 1'b1, 1'b0, 1'b0},
        '{STEP_WRITE, CFG_SYM_LOW,  64'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_TEXT,  CFG_SYM_LOW,  64'd0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0},
        // pattern swapped inside a string
        '{STEP_WRITE, CFG_SYM_LOW,  64'h3F, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_TEXT,  CFG_SYM_LOW,  64'd0, 8'h71, 1'b1, 1'b0, 1'b0, 1'b0},
        '{STEP_WRITE, CFG_LENGTH,   64'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{STEP_TEXT,  CFG_SYM_LOW,  64'd0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [7:0]            i_s_axis_tdata = '0;   // [7:0] text_char
    logic                  i_s_axis_tuser = 1'b0; // [0] has_char
    logic                  i_s_axis_tlast = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [7:0]            o_m_axis_tdata;        // [0] matched, [7:1] zero
    logic                  o_m_axis_tlast;

    // matcher model
    logic [63:0] pat_low = '0;
    logic [63:0] pat_high = '0;
    logic [4:0]  pat_len = '0;
    logic [16:0] dp_row = '0;
    bit          fresh_string = 1'b1;

    answer_t answers_due[$];
    int      fault_count = 0;
    int      items_sent = 0;
    int      send_odds = 0;   // 0: no gaps, else a gap before an item at odds of one in send_odds
    int      stall_odds = 0;
    int      stall_left = 0;

    wildcard_glob_matcher u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [7:0] pat_sym(input int k);
        return (k < 8) ? pat_low[8*k +: 8] : pat_high[8*(k-8) +: 8];
    endfunction

    function automatic int pat_used();
        return (pat_len > 5'd16) ? 16 : int'(pat_len);
    endfunction

    function automatic answer_t glob_advance(input logic [7:0] ch, input bit has,
                                             input bit last);
        logic [16:0] row;
        logic [16:0] nxt;
        logic [7:0]  s;
        int          n;
        int          j;
        answer_t     a;
        n = pat_used();
        row = dp_row;
        if (fresh_string) begin
            // empty-text row: leading stars stay reachable
            row = 17'd1;
            for (j = 0; j < n; j++) begin
                if (pat_sym(j) == SYM_STAR && row[j])
                    row[j+1] = 1'b1;
            end
        end
        if (has) begin
            nxt = '0;
            for (j = 1; j <= n; j++) begin
                s = pat_sym(j-1);
                if (s == SYM_STAR)
                    nxt[j] = nxt[j-1] | row[j];
                else
                    nxt[j] = row[j-1] & ((s == ch) || (s == SYM_ANY));
            end
            row = nxt;
        end
        dp_row = row;
        fresh_string = last;
        a.matched = row[n];
        a.end_of_text = last;
        return a;
    endfunction

    task automatic send_text(input logic [7:0] ch, input bit has, input bit last,
                             input bit typed = 1'b0, input bit want = 1'b0);
        int      gap;
        answer_t a;
        gap = (send_odds != 0 && $urandom_range(0, send_odds-1) == 0) ?
              $urandom_range(1, 16) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ch;
        i_s_axis_tuser  <= has;
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        a = glob_advance(ch, has, last);
        if (typed)
            a.matched = want;
        answers_due.push_back(a);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_index idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_SYM_LOW:  pat_low = val;
            CFG_SYM_HIGH: pat_high = val;
            CFG_LENGTH:   pat_len = val[4:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // result side back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left--;
        end else if (stall_odds != 0 && $urandom_range(0, stall_odds-1) == 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 15);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        answer_t a;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (answers_due.size() == 0) begin
                if (fault_count < 10)
                    $display("result with no item pending: tdata %02h last %0b",
                             o_m_axis_tdata, o_m_axis_tlast);
                fault_count++;
            end else begin
                a = answers_due.pop_front();
                if (o_m_axis_tdata !== {7'b0, a.matched} ||
                    o_m_axis_tlast !== a.end_of_text) begin
                    if (fault_count < 10)
                        $display("mismatch at %0t: expected matched %0b last %0b, got tdata %02h last %0b",
                                 $realtime, a.matched, a.end_of_text,
                                 o_m_axis_tdata, o_m_axis_tlast);
                    fault_count++;
                end
            end
        end
    end

    initial begin
        logic [63:0] lo;
        logic [63:0] hi;
        logic [7:0]  s;
        logic [7:0]  text_q[$];
        int          k;
        int          r;
        int          n;
        int          phase_start;
        int          phase_len;
        bit          first;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_odds  = 6;
        stall_odds = 6;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == STEP_WRITE) begin
                drain();
                cfg_write(directed_rows[i].reg_idx, directed_rows[i].value);
            end else begin
                send_text(directed_rows[i].ch, directed_rows[i].has, directed_rows[i].last,
                          directed_rows[i].typed, directed_rows[i].want);
            end
        end

        first = 1'b1;
        lo = '0;
        hi = '0;
        while (items_sent < ITEM_GOAL) begin
            drain();
            if (items_sent >= ITEM_GOAL - 150) begin
                send_odds  = 0;
                stall_odds = 0;
            end else begin
                r = $urandom_range(0, 3);
                send_odds  = (r == 0) ? 0 : (r == 1) ? 3 : 10;
                r = $urandom_range(0, 3);
                stall_odds = (r == 0) ? 0 : (r == 1) ? 3 : 10;
            end

            for (k = 0; k < 16; k++) begin
                r = $urandom_range(0, 9);
                s = (r < 3) ? SYM_STAR : (r < 5) ? SYM_ANY :
                    (r < 9) ? 8'h61 + $urandom_range(0, 3) : $urandom_range(0, 255);
                if (k < 8)
                    lo[8*k +: 8] = s;
                else
                    hi[8*(k-8) +: 8] = s;
            end
            r = $urandom_range(0, 15);
            if (r == 0)
                lo = '1;
            else if (r == 1)
                lo = '0;
            else if (r == 2)
                hi = '1;
            if (first || $urandom_range(0, 3) != 0)
                cfg_write(CFG_SYM_LOW, lo);
            if (first || $urandom_range(0, 3) != 0)
                cfg_write(CFG_SYM_HIGH, hi);
            if (first || $urandom_range(0, 3) != 0) begin
                r = $urandom_range(0, 11);
                cfg_write(CFG_LENGTH, (r == 0) ? 0 : (r == 1) ? 16 :
                          (r == 2) ? $urandom_range(17, 31) : $urandom_range(1, 16));
            end
            first = 1'b0;

            n = pat_used();
            phase_start = items_sent;
            phase_len = $urandom_range(40, 120);
            while (items_sent - phase_start < phase_len && items_sent < ITEM_GOAL) begin
                text_q.delete();
                r = $urandom_range(0, 9);
                if (r == 1) begin
                    repeat ($urandom_range(1, 20)) text_q.push_back($urandom_range(0, 255));
                end else if (r != 0) begin
                    // text shaped after the pattern, lightly mutated
                    for (k = 0; k < n; k++) begin
                        s = pat_sym(k);
                        if (s == SYM_STAR) begin
                            repeat ($urandom_range(0, 3))
                                text_q.push_back($urandom_range(0, 1) ?
                                                 8'h61 + $urandom_range(0, 3) :
                                                 $urandom_range(0, 255));
                        end else if (s == SYM_ANY) begin
                            text_q.push_back($urandom_range(0, 255));
                        end else begin
                            text_q.push_back(($urandom_range(0, 19) == 0) ?
                                             $urandom_range(0, 255) : s);
                        end
                    end
                    r = $urandom_range(0, 7);
                    if (r == 0)
                        text_q.push_back($urandom_range(0, 255));
                    else if (r == 1 && text_q.size() != 0)
                        void'(text_q.pop_back());
                end
                if (text_q.size() == 0) begin
                    send_text($urandom_range(0, 255), 1'b0, 1'b1);
                end else begin
                    foreach (text_q[i]) begin
                        if ($urandom_range(0, 14) == 0)
                            send_text($urandom_range(0, 255), 1'b0, 1'b0);
                        send_text(text_q[i], 1'b1, i == text_q.size() - 1);
                    end
                end
            end
            // leave a string open so the next pattern picks up its row
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3)) send_text($urandom_range(0, 255), 1'b1, 1'b0);
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fault_count == 0 && answers_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
